// ===== rtl/i2cm_pkg.sv =====
`default_nettype none

package i2cm_pkg;

    // Word widths on the stream ports
    localparam int IN_W   = 16;
    localparam int OUT_W  = 16;
    localparam int CNT_W  = 11;

    // Configuration register indexes
    localparam logic CFG_UNIT_TICKS  = 1'b0;
    localparam logic CFG_ACK_TIMEOUT = 1'b1;

    // Reset values of the configuration registers
    localparam logic [7:0] UNIT_TICKS_RST  = 8'd72;
    localparam logic [7:0] ACK_TIMEOUT_RST = 8'd250;

    // Bits per byte on the bus
    localparam logic [3:0] BYTE_BITS = 4'd8;

    // Delay lengths in units
    localparam logic [2:0] UNITS_1 = 3'd1;
    localparam logic [2:0] UNITS_2 = 3'd2;
    localparam logic [2:0] UNITS_4 = 3'd4;

    // Command codes
    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_START = 3'd1,
        OP_STOP  = 3'd2,
        OP_SEND  = 3'd3,
        OP_WAIT  = 3'd4,
        OP_READ  = 3'd5
    } op_t;

    // Sequencer phases
    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_ST_HOLD  = 4'd1,
        PH_ST_LOW   = 4'd2,
        PH_SP_LOW   = 4'd3,
        PH_SP_HIGH  = 4'd4,
        PH_WA_REL   = 4'd5,
        PH_WA_CLK   = 4'd6,
        PH_WA_POLL  = 4'd7,
        PH_TX_DATA  = 4'd8,
        PH_TX_HIGH  = 4'd9,
        PH_TX_LOW   = 4'd10,
        PH_RX_LOW   = 4'd11,
        PH_RX_HIGH  = 4'd12,
        PH_AK_DRIVE = 4'd13,
        PH_AK_HIGH  = 4'd14
    } phase_t;

    // One input word, unpacked
    typedef struct packed {
        logic       sda_in;
        logic       send_ack;
        logic [7:0] tx_byte;
        logic [2:0] op;
    } item_t;

    // Configuration register values
    typedef struct packed {
        logic [7:0] unit_ticks;
        logic [7:0] ack_timeout;
    } cfg_t;

    // Sequencer state
    typedef struct packed {
        phase_t     phase;
        logic [3:0] bit_count;
        logic [7:0] shift;
        logic [CNT_W-1:0] delay;
        logic [7:0] timeout;
        logic       scl;
        logic       sda;
        logic       sda_oe;
        logic [7:0] rx;
        logic       fail;
        logic       ack_keep;
    } state_t;

    // Ticks of a delay of the given number of units
    function automatic logic [CNT_W-1:0] unit_delay(input logic [7:0] ticks,
                                                    input logic [2:0] units);
        logic [CNT_W-1:0] prod;
        prod = CNT_W'(ticks) * CNT_W'(units);
        return prod;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/i2cm_step.sv =====
`default_nettype none

module i2cm_step (
    input  wire i2cm_pkg::state_t cur,
    input  wire i2cm_pkg::item_t  item,
    input  wire i2cm_pkg::cfg_t   cfg,
    output i2cm_pkg::state_t      nxt,
    output logic                  done
);
    import i2cm_pkg::*;

    // Work out one tick of the bus sequence
    always_comb
    begin
        nxt  = cur;
        done = 1'b0;
        if (cur.phase == PH_IDLE)
        begin
            // Take a new command
            case (op_t'(item.op))
                OP_START:
                begin
                    nxt.sda_oe = 1'b1;
                    nxt.sda    = 1'b1;
                    nxt.scl    = 1'b1;
                    nxt.phase  = PH_ST_HOLD;
                    nxt.delay  = unit_delay(cfg.unit_ticks, UNITS_4);
                end
                OP_STOP:
                begin
                    nxt.sda_oe = 1'b1;
                    nxt.scl    = 1'b0;
                    nxt.sda    = 1'b0;
                    nxt.phase  = PH_SP_LOW;
                    nxt.delay  = unit_delay(cfg.unit_ticks, UNITS_4);
                end
                OP_SEND:
                begin
                    nxt.sda_oe    = 1'b1;
                    nxt.scl       = 1'b0;
                    nxt.sda       = item.tx_byte[7];
                    nxt.shift     = {item.tx_byte[6:0], 1'b0};
                    nxt.bit_count = 4'd1;
                    nxt.phase     = PH_TX_DATA;
                    nxt.delay     = unit_delay(cfg.unit_ticks, UNITS_2);
                end
                OP_WAIT:
                begin
                    nxt.fail    = 1'b0;
                    nxt.timeout = '0;
                    nxt.sda_oe  = 1'b0;
                    nxt.sda     = 1'b1;
                    nxt.phase   = PH_WA_REL;
                    nxt.delay   = unit_delay(cfg.unit_ticks, UNITS_1);
                end
                OP_READ:
                begin
                    nxt.sda_oe    = 1'b0;
                    nxt.scl       = 1'b0;
                    nxt.shift     = '0;
                    nxt.bit_count = '0;
                    nxt.ack_keep  = item.send_ack;
                    nxt.phase     = PH_RX_LOW;
                    nxt.delay     = unit_delay(cfg.unit_ticks, UNITS_2);
                end
                default:
                begin
                    nxt = cur;
                end
            endcase
        end
        else if (cur.phase == PH_WA_POLL ||
                 (cur.phase == PH_WA_CLK && cur.delay <= CNT_W'(1)))
        begin
            // Poll for acknowledge once per tick
            nxt.phase = PH_WA_POLL;
            if (!item.sda_in)
            begin
                nxt.scl   = 1'b0;
                nxt.phase = PH_IDLE;
                nxt.delay = '0;
                done      = 1'b1;
            end
            else if (cur.timeout >= cfg.ack_timeout)
            begin
                nxt.fail   = 1'b1;
                nxt.sda_oe = 1'b1;
                nxt.scl    = 1'b0;
                nxt.sda    = 1'b0;
                nxt.phase  = PH_SP_LOW;
                nxt.delay  = unit_delay(cfg.unit_ticks, UNITS_4);
            end
            else
            begin
                nxt.timeout = cur.timeout + 8'd1;
            end
        end
        else if (cur.delay > CNT_W'(1))
        begin
            // Count down the current segment
            nxt.delay = cur.delay - CNT_W'(1);
        end
        else
        begin
            // Segment over: apply the next step
            case (cur.phase)
                PH_ST_HOLD:
                begin
                    nxt.sda   = 1'b0;
                    nxt.phase = PH_ST_LOW;
                    nxt.delay = unit_delay(cfg.unit_ticks, UNITS_4);
                end
                PH_ST_LOW:
                begin
                    // Pull SCL low to finish the start condition
                    nxt.scl   = 1'b0;
                    nxt.phase = PH_IDLE;
                    nxt.delay = '0;
                    done      = 1'b1;
                end
                PH_SP_LOW:
                begin
                    nxt.scl   = 1'b1;
                    nxt.sda   = 1'b1;
                    nxt.phase = PH_SP_HIGH;
                    nxt.delay = unit_delay(cfg.unit_ticks, UNITS_4);
                end
                PH_WA_REL:
                begin
                    nxt.scl   = 1'b1;
                    nxt.phase = PH_WA_CLK;
                    nxt.delay = unit_delay(cfg.unit_ticks, UNITS_1);
                end
                PH_TX_DATA:
                begin
                    nxt.scl   = 1'b1;
                    nxt.phase = PH_TX_HIGH;
                    nxt.delay = unit_delay(cfg.unit_ticks, UNITS_2);
                end
                PH_TX_HIGH:
                begin
                    nxt.scl   = 1'b0;
                    nxt.phase = PH_TX_LOW;
                    nxt.delay = unit_delay(cfg.unit_ticks, UNITS_2);
                end
                PH_TX_LOW:
                begin
                    if (cur.bit_count >= BYTE_BITS)
                    begin
                        nxt.phase = PH_IDLE;
                        nxt.delay = '0;
                        done      = 1'b1;
                    end
                    else
                    begin
                        nxt.sda       = cur.shift[7];
                        nxt.shift     = {cur.shift[6:0], 1'b0};
                        nxt.bit_count = cur.bit_count + 4'd1;
                        nxt.phase     = PH_TX_DATA;
                        nxt.delay     = unit_delay(cfg.unit_ticks, UNITS_2);
                    end
                end
                PH_RX_LOW:
                begin
                    nxt.scl       = 1'b1;
                    nxt.shift     = {cur.shift[6:0], item.sda_in};
                    nxt.bit_count = cur.bit_count + 4'd1;
                    nxt.phase     = PH_RX_HIGH;
                    nxt.delay     = unit_delay(cfg.unit_ticks, UNITS_1);
                end
                PH_RX_HIGH:
                begin
                    nxt.scl = 1'b0;
                    if (cur.bit_count >= BYTE_BITS)
                    begin
                        nxt.sda_oe = 1'b1;
                        nxt.sda    = !cur.ack_keep;
                        nxt.phase  = PH_AK_DRIVE;
                    end
                    else
                    begin
                        nxt.phase = PH_RX_LOW;
                    end
                    nxt.delay = unit_delay(cfg.unit_ticks, UNITS_2);
                end
                PH_AK_DRIVE:
                begin
                    nxt.scl   = 1'b1;
                    nxt.phase = PH_AK_HIGH;
                    nxt.delay = unit_delay(cfg.unit_ticks, UNITS_2);
                end
                PH_AK_HIGH:
                begin
                    nxt.scl   = 1'b0;
                    nxt.rx    = cur.shift;
                    nxt.phase = PH_IDLE;
                    nxt.delay = '0;
                    done      = 1'b1;
                end
                default:
                begin
                    // Stop high and any stray code end here
                    nxt.phase = PH_IDLE;
                    nxt.delay = '0;
                    done      = 1'b1;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/i2c_master_bit_engine.sv =====
`default_nettype none

// Single-master I2C bit engine. Every input word is one tick of the bus
// sequencer and produces exactly one output word with the SCL level, the
// SDA level and enable, busy, a done pulse, the last byte read and the
// acknowledge-failure flag. A command in the op field is taken only while
// the engine is idle; delays are whole units of unit_ticks ticks. The
// engine takes one word per clock cycle while the output is not stalled; the
// word is held in the input register, then the combinational step logic
// loads its result into the output register, which sets that rate.
// A stalled output holds the input register until the result drains.
// Configuration writes are taken at any time and are meant for idle periods.
module i2c_master_bit_engine (
    input  wire                        clk,
    input  wire                        rst_n,
    // s_axis_tdata: op[2:0], tx_byte[10:3], send_ack[11], sda_in[12], zeros above
    input  wire                        s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire [i2cm_pkg::IN_W-1:0]   s_axis_tdata,
    // m_axis_tdata: scl[0], sda_level[1], sda_enable[2], busy_res[3],
    // done_res[4], rx_byte[12:5], ack_fail[13], zeros above
    output logic                       m_axis_tvalid,
    input  wire                        m_axis_tready,
    output logic [i2cm_pkg::OUT_W-1:0] m_axis_tdata,
    input  wire                        cfg_valid,
    output logic                       cfg_ready,
    input  wire                        cfg_index,
    input  wire [7:0]                  cfg_data
);
    import i2cm_pkg::*;

    logic          in_valid_reg;
    item_t         in_data_reg;
    logic          out_valid_reg;
    logic [OUT_W-1:0] out_data_reg;
    cfg_t          cfg_reg;
    state_t        st_reg;
    state_t        st_next;
    logic          done;
    logic          fire;

    // Step the held word when the output register can take its result
    assign fire          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || fire;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    i2cm_step u_step (
        .cur  (st_reg),
        .item (in_data_reg),
        .cfg  (cfg_reg),
        .nxt  (st_next),
        .done (done)
    );

    // Hold the configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.unit_ticks  <= UNIT_TICKS_RST;
            cfg_reg.ack_timeout <= ACK_TIMEOUT_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_UNIT_TICKS:  cfg_reg.unit_ticks  <= cfg_data;
                CFG_ACK_TIMEOUT: cfg_reg.ack_timeout <= cfg_data;
                default:         cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Capture an input word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_data_reg <= item_t'(s_axis_tdata[12:0]);
        end
    end

    // Advance the sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.phase     <= PH_IDLE;
            st_reg.bit_count <= '0;
            st_reg.shift     <= '0;
            st_reg.delay     <= '0;
            st_reg.timeout   <= '0;
            st_reg.scl       <= 1'b1;
            st_reg.sda       <= 1'b1;
            st_reg.sda_oe    <= 1'b1;
            st_reg.rx        <= '0;
            st_reg.fail      <= 1'b0;
            st_reg.ack_keep  <= 1'b0;
        end
        else if (fire)
        begin
            st_reg <= st_next;
        end
    end

    // Load the output word; drop valid once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_data_reg <= {2'b00, st_next.fail, st_next.rx, done,
                             (st_next.phase != PH_IDLE), st_next.sda_oe,
                             st_next.sda, st_next.scl};
        end
    end

`ifndef SYNTHESIS
    // Idle sequencer never has a segment count pending
    a_idle_no_delay: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.phase == PH_IDLE |-> st_reg.delay == '0)
        else $error("delay count left over in idle");

    // Bit counter never runs past one byte
    a_bit_count: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.bit_count <= BYTE_BITS)
        else $error("bit count beyond one byte");

    // Acknowledge failure always starts the stop sequence
    a_fail_stop: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(st_reg.fail) |-> st_reg.phase == PH_SP_LOW)
        else $error("ack failure without stop");

    // Low SDA while polling ends the command with done
    a_ack_done: assert property (@(posedge clk) disable iff (!rst_n)
        fire && st_reg.phase == PH_WA_POLL && !in_data_reg.sda_in
        |=> out_valid_reg && out_data_reg[4] && st_reg.phase == PH_IDLE)
        else $error("acknowledge did not complete the command");
`endif

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import i2cm_pkg::*;

    // Cycles without any handshake before the run is declared hung
    localparam int QUIET_LIMIT = 2000;
    // Length of the one long receiver hold-off
    localparam int LONG_HOLD   = 80;
    // Op codes the engine treats like no command
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    // Engine state as tracked by the bench
    typedef struct packed {
        phase_t           phase;
        logic [3:0]       bits;
        logic [7:0]       shift;
        logic [CNT_W-1:0] delay;
        logic [7:0]       tmo;
        logic             scl;
        logic             sda;
        logic             oe;
        logic [7:0]       rx;
        logic             fail;
        logic             keep;
        logic             done;
    } eng_t;

    // Output word layout, lowest field last
    typedef struct packed {
        logic       ack_fail;
        logic [7:0] rx_byte;
        logic       done_res;
        logic       busy_res;
        logic       sda_enable;
        logic       sda_level;
        logic       scl;
    } line_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata = '0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic             cfg_index = 1'b0;
    logic [7:0]       cfg_data = '0;

    i2c_master_bit_engine u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Pending ticks for the driver and predicted bus lines for the checker
    item_t tick_q[$];
    line_t line_q[$];

    // Planning copy of the engine, used to shape well-formed command runs
    eng_t       eng_plan;
    logic [7:0] plan_unit  = UNIT_TICKS_RST;
    logic [7:0] plan_ackto = ACK_TIMEOUT_RST;
    int         planned    = 0;
    int         rx_force   = -1;

    // Checking copy of the engine, advanced on accepted words
    eng_t       eng_now;
    logic [7:0] now_unit;
    logic [7:0] now_ackto;

    int send_idle = 0;
    int recv_idle = 0;
    bit long_hold = 1'b0;
    int errors    = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Engine prediction
    // ------------------------------------------------------------------
    function automatic eng_t engine_reset();
        eng_t s;
        s       = '0;
        s.phase = PH_IDLE;
        s.scl   = 1'b1;
        s.sda   = 1'b1;
        s.oe    = 1'b1;
        return s;
    endfunction

    // Load a delay segment of the given length in units
    function automatic eng_t seg_enter(input eng_t s, input phase_t p,
                                       input logic [2:0] units, input logic [7:0] unit);
        s.phase = p;
        s.delay = CNT_W'(units) * CNT_W'(unit);
        return s;
    endfunction

    function automatic eng_t seg_done(input eng_t s);
        s.phase = PH_IDLE;
        s.delay = '0;
        s.done  = 1'b1;
        return s;
    endfunction

    // Pull SCL and SDA low; both are released when the PH_SP_LOW segment ends
    function automatic eng_t stop_begin(input eng_t s, input logic [7:0] unit);
        s.oe  = 1'b1;
        s.scl = 1'b0;
        s.sda = 1'b0;
        return seg_enter(s, PH_SP_LOW, UNITS_4, unit);
    endfunction

    // Put the next data bit on SDA, msb first
    function automatic eng_t shift_out(input eng_t s, input logic [7:0] unit);
        s.sda   = s.shift[7];
        s.shift = {s.shift[6:0], 1'b0};
        s.bits  = s.bits + 4'd1;
        return seg_enter(s, PH_TX_DATA, UNITS_2, unit);
    endfunction

    // One acknowledge sample: low ends the wait, too many highs abort
    function automatic eng_t ack_poll(input eng_t s, input logic sda,
                                      input logic [7:0] ackto, input logic [7:0] unit);
        if (!sda)
        begin
            s.scl = 1'b0;
            return seg_done(s);
        end
        if (s.tmo >= ackto)
        begin
            s.fail = 1'b1;
            return stop_begin(s, unit);
        end
        s.tmo = s.tmo + 8'd1;
        return s;
    endfunction

    // Advance the engine by one tick
    function automatic eng_t engine_tick(input eng_t s, input logic [7:0] unit,
                                         input logic [7:0] ackto, input item_t it);
        s.done = 1'b0;
        if (s.phase == PH_IDLE)
        begin
            case (it.op)
                OP_START:
                begin
                    s.oe  = 1'b1;
                    s.sda = 1'b1;
                    s.scl = 1'b1;
                    s     = seg_enter(s, PH_ST_HOLD, UNITS_4, unit);
                end
                OP_STOP:
                    s = stop_begin(s, unit);
                OP_SEND:
                begin
                    s.oe    = 1'b1;
                    s.scl   = 1'b0;
                    s.shift = it.tx_byte;
                    s.bits  = '0;
                    s       = shift_out(s, unit);
                end
                OP_WAIT:
                begin
                    s.fail = 1'b0;
                    s.tmo  = '0;
                    s.oe   = 1'b0;
                    s.sda  = 1'b1;
                    s      = seg_enter(s, PH_WA_REL, UNITS_1, unit);
                end
                OP_READ:
                begin
                    s.oe    = 1'b0;
                    s.scl   = 1'b0;
                    s.shift = '0;
                    s.bits  = '0;
                    s.keep  = it.send_ack;
                    s       = seg_enter(s, PH_RX_LOW, UNITS_2, unit);
                end
                default: ;
            endcase
        end
        else if (s.phase == PH_WA_POLL)
            s = ack_poll(s, it.sda_in, ackto, unit);
        else if (s.delay > CNT_W'(1))
            s.delay = s.delay - CNT_W'(1);
        else
        begin
            case (s.phase)
                PH_ST_HOLD:
                begin
                    s.sda = 1'b0;
                    s     = seg_enter(s, PH_ST_LOW, UNITS_4, unit);
                end
                PH_ST_LOW:
                begin
                    s.scl = 1'b0;
                    s     = seg_done(s);
                end
                PH_SP_LOW:
                begin
                    s.scl = 1'b1;
                    s.sda = 1'b1;
                    s     = seg_enter(s, PH_SP_HIGH, UNITS_4, unit);
                end
                PH_SP_HIGH:
                    s = seg_done(s);
                PH_WA_REL:
                begin
                    s.scl = 1'b1;
                    s     = seg_enter(s, PH_WA_CLK, UNITS_1, unit);
                end
                PH_WA_CLK:
                begin
                    s.phase = PH_WA_POLL;
                    s       = ack_poll(s, it.sda_in, ackto, unit);
                end
                PH_TX_DATA:
                begin
                    s.scl = 1'b1;
                    s     = seg_enter(s, PH_TX_HIGH, UNITS_2, unit);
                end
                PH_TX_HIGH:
                begin
                    s.scl = 1'b0;
                    s     = seg_enter(s, PH_TX_LOW, UNITS_2, unit);
                end
                PH_TX_LOW:
                begin
                    if (s.bits >= BYTE_BITS)
                        s = seg_done(s);
                    else
                        s = shift_out(s, unit);
                end
                PH_RX_LOW:
                begin
                    s.scl   = 1'b1;
                    s.shift = {s.shift[6:0], it.sda_in};
                    s.bits  = s.bits + 4'd1;
                    s       = seg_enter(s, PH_RX_HIGH, UNITS_1, unit);
                end
                PH_RX_HIGH:
                begin
                    s.scl = 1'b0;
                    if (s.bits >= BYTE_BITS)
                    begin
                        s.oe  = 1'b1;
                        s.sda = !s.keep;
                        s     = seg_enter(s, PH_AK_DRIVE, UNITS_2, unit);
                    end
                    else
                        s = seg_enter(s, PH_RX_LOW, UNITS_2, unit);
                end
                PH_AK_DRIVE:
                begin
                    s.scl = 1'b1;
                    s     = seg_enter(s, PH_AK_HIGH, UNITS_2, unit);
                end
                PH_AK_HIGH:
                begin
                    s.scl = 1'b0;
                    s.rx  = s.shift;
                    s     = seg_done(s);
                end
                default:
                    s = seg_done(s);
            endcase
        end
        return s;
    endfunction

    function automatic line_t bus_line(input eng_t s);
        line_t l;
        l.scl        = s.scl;
        l.sda_level  = s.sda;
        l.sda_enable = s.oe;
        l.busy_res   = (s.phase != PH_IDLE);
        l.done_res   = s.done;
        l.rx_byte    = s.rx;
        l.ack_fail   = s.fail;
        return l;
    endfunction

    // ------------------------------------------------------------------
    // Mismatch reporting
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    endtask

    task automatic check_field(input string what, input int got, input int want);
        if (got != want)
            report_mismatch(what, got, want);
    endtask

    // ------------------------------------------------------------------
    // Sender: offer pending ticks, idling at random
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (tick_q.size() > 0 && $urandom_range(0, 99) >= send_idle)
            begin
                s_axis_tdata  <= IN_W'(tick_q.pop_front());
                s_axis_tvalid <= 1'b1;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random back-pressure plus one long hold-off
    // ------------------------------------------------------------------
    int hold_left;
    bit hold_used;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            hold_left     <= 0;
            hold_used     <= 1'b0;
        end
        else if (long_hold && !hold_used)
        begin
            hold_left     <= LONG_HOLD;
            hold_used     <= 1'b1;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle);
    end

    // ------------------------------------------------------------------
    // Checker: compare output words, then predict for accepted inputs
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : scoreboard
        line_t got;
        line_t want;
        if (!rst_n)
        begin
            eng_now   = engine_reset();
            now_unit  = UNIT_TICKS_RST;
            now_ackto = ACK_TIMEOUT_RST;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = line_t'(m_axis_tdata[$bits(line_t)-1:0]);
                if (line_q.size() == 0)
                    report_mismatch("unexpected output word", int'(got), 0);
                else
                begin
                    want = line_q.pop_front();
                    check_field("scl", int'(got.scl), int'(want.scl));
                    check_field("sda_level", int'(got.sda_level), int'(want.sda_level));
                    check_field("sda_enable", int'(got.sda_enable),
                                int'(want.sda_enable));
                    check_field("busy_res", int'(got.busy_res), int'(want.busy_res));
                    check_field("done_res", int'(got.done_res), int'(want.done_res));
                    check_field("rx_byte", int'(got.rx_byte), int'(want.rx_byte));
                    check_field("ack_fail", int'(got.ack_fail), int'(want.ack_fail));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                eng_now = engine_tick(eng_now, now_unit, now_ackto,
                                      item_t'(s_axis_tdata[$bits(item_t)-1:0]));
                line_q.push_back(bus_line(eng_now));
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_UNIT_TICKS)
                    now_unit = cfg_data;
                else
                    now_ackto = cfg_data;
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: abort when no handshake happens for too long
    // ------------------------------------------------------------------
    int quiet = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (cfg_valid && cfg_ready))
                quiet <= 0;
            else if (quiet >= QUIET_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
            else
                quiet <= quiet + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus planning
    // ------------------------------------------------------------------
    task automatic push_tick(input logic [2:0] op, input logic [7:0] tx,
                             input logic ack, input logic sda);
        item_t it;
        it.op       = op;
        it.tx_byte  = tx;
        it.send_ack = ack;
        it.sda_in   = sda;
        tick_q.push_back(it);
        eng_plan = engine_tick(eng_plan, plan_unit, plan_ackto, it);
        planned++;
    endtask

    // SDA seen by the engine: ACK after a set number of high samples
    function automatic logic line_sda(input int ack_after);
        if (eng_plan.phase == PH_WA_CLK || eng_plan.phase == PH_WA_POLL)
            return int'(eng_plan.tmo) < ack_after;
        if (rx_force >= 0)
            return rx_force[0];
        return 1'($urandom_range(0, 1));
    endfunction

    // Issue one command and fill ticks until the engine is idle again
    task automatic run_cmd(input logic [2:0] op, input logic [7:0] tx,
                           input logic ack, input int ack_after);
        push_tick(op, tx, ack, 1'($urandom_range(0, 1)));
        while (eng_plan.phase != PH_IDLE)
            push_tick(3'($urandom_range(0, 7)), 8'($urandom),
                      1'($urandom_range(0, 1)), line_sda(ack_after));
    endtask

    task automatic run_idle(input int n);
        logic [2:0] op;
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 2))
                0: op = OP_NONE;
                1: op = OP_SPARE_6;
                default: op = OP_SPARE_7;
            endcase
            push_tick(op, 8'($urandom), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
        end
    endtask

    // High samples before the slave answers, weighted toward the timeout edge
    function automatic int pick_ack();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 0;
            7: return int'(plan_ackto);
            8: return int'(plan_ackto) + 1;
            default: return $urandom_range(0, plan_ackto);
        endcase
    endfunction

    // Start, address, acknowledge, up to three bytes, stop (optional on failure)
    task automatic bus_transfer();
        int n;
        run_cmd(OP_START, 8'($urandom), 1'($urandom_range(0, 1)), 0);
        run_cmd(OP_SEND, 8'($urandom), 1'($urandom_range(0, 1)), 0);
        run_cmd(OP_WAIT, 8'($urandom), 1'($urandom_range(0, 1)), pick_ack());
        n = $urandom_range(0, 3);
        for (int i = 0; i < n && !eng_plan.fail; i++)
        begin
            if ($urandom_range(0, 1))
            begin
                run_cmd(OP_SEND, 8'($urandom), 1'($urandom_range(0, 1)), 0);
                run_cmd(OP_WAIT, 8'($urandom), 1'($urandom_range(0, 1)), pick_ack());
            end
            else
                run_cmd(OP_READ, 8'($urandom), 1'($urandom_range(0, 1)), 0);
        end
        if (!eng_plan.fail || $urandom_range(0, 1))
            run_cmd(OP_STOP, 8'($urandom), 1'($urandom_range(0, 1)), 0);
    endtask

    task automatic random_traffic(input int budget);
        int stop_at;
        stop_at = planned + budget;
        while (planned < stop_at)
        begin
            // mostly complete transfers, some stray commands
            if ($urandom_range(0, 3) == 0)
                run_cmd(3'($urandom_range(0, 7)), 8'($urandom),
                        1'($urandom_range(0, 1)), pick_ack());
            else
                bus_transfer();
            run_idle($urandom_range(0, 3));
        end
    endtask

    // ------------------------------------------------------------------
    // Register writes and phase boundaries
    // ------------------------------------------------------------------
    task automatic write_reg(input logic idx, input logic [7:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_UNIT_TICKS)
            plan_unit = val;
        else
            plan_ackto = val;
    endtask

    // Hold until every word is sent and every result is back
    task automatic settle();
        while (tick_q.size() != 0 || s_axis_tvalid || line_q.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic new_setting(input logic [7:0] unit, input logic [7:0] ackto,
                               input int s_idle, input int r_idle);
        settle();
        write_reg(CFG_UNIT_TICKS, unit);
        write_reg(CFG_ACK_TIMEOUT, ackto);
        @(negedge clk);
        send_idle = s_idle;
        recv_idle = r_idle;
    endtask

    initial
    begin
        eng_plan = engine_reset();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n     = 1'b1;
        send_idle = 26;
        recv_idle = 78;

        // Reset settings: acknowledge after three high samples
        run_cmd(OP_WAIT, 8'h00, 1'b0, 3);

        // Zero unit length and zero timeout, full transfer with data extremes
        new_setting(8'd0, 8'd0, 26, 78);
        run_idle(3);
        run_cmd(OP_START, 8'h00, 1'b0, 0);
        run_cmd(OP_SEND, 8'h00, 1'b0, 0);
        run_cmd(OP_WAIT, 8'h00, 1'b0, 0);
        run_cmd(OP_SEND, 8'hFF, 1'b1, 0);
        run_cmd(OP_WAIT, 8'hFF, 1'b1, 1);
        rx_force = 0;
        run_cmd(OP_READ, 8'h00, 1'b1, 0);
        rx_force = 1;
        run_cmd(OP_READ, 8'h00, 1'b0, 0);
        rx_force = -1;
        run_cmd(OP_READ, 8'h5A, 1'b1, 0);
        run_cmd(OP_STOP, 8'h00, 1'b0, 0);
        run_idle(2);

        // Unit of one tick, longest timeout, answer one sample too late
        new_setting(8'd1, 8'd255, 26, 78);
        run_cmd(OP_WAIT, 8'h00, 1'b0, 256);

        // Random transfers under changing settings and flow control
        new_setting(8'($urandom_range(0, 1)), 8'($urandom_range(0, 15)), 78, 26);
        random_traffic(80);
        new_setting(8'd0, 8'($urandom_range(1, 8)), 0, 0);
        random_traffic(80);
        long_hold = 1'b1;

        settle();
        if (errors == 0 && line_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
